FILE: hw/rtl/cic_pkg.sv
`default_nettype none
package cic_pkg;

    typedef enum logic [2:0] {
        OP_LINE      = 3'd0,
        OP_PWRITE    = 3'd1,
        OP_PREAD     = 3'd2,
        OP_TWRITE    = 3'd3,
        OP_TREAD     = 3'd4,
        OP_ACK       = 3'd5,
        OP_RSVD6     = 3'd6,
        OP_RSVD7     = 3'd7
    } op_t;

    localparam logic [5:0] MF_POLL  = 6'h01;
    localparam logic [5:0] MF_RDISR = 6'h02;
    localparam logic [5:0] MF_AEOI  = 6'h04;
    localparam logic [5:0] MF_RAEOI = 6'h08;
    localparam logic [5:0] MF_SFNM  = 6'h10;
    localparam logic [5:0] MF_INIT4 = 6'h20;

    localparam logic [7:0] ICW1_BIT = 8'h10;
    localparam logic [7:0] OCW3_BIT = 8'h08;
    localparam logic [7:0] POLL_BIT = 8'h04;
    localparam logic [7:0] BASE_MSK = 8'hF8;
    localparam logic [7:0] CASC_BIT = 8'h04;
    localparam logic [7:0] SPURIOUS = 8'h07;

    localparam logic [2:0] CMD_RAEOI_CLR = 3'd0;
    localparam logic [2:0] CMD_EOI       = 3'd1;
    localparam logic [2:0] CMD_NOP       = 3'd2;
    localparam logic [2:0] CMD_SEOI      = 3'd3;
    localparam logic [2:0] CMD_RAEOI_SET = 3'd4;
    localparam logic [2:0] CMD_ROT_EOI   = 3'd5;
    localparam logic [2:0] CMD_SET_PRIO  = 3'd6;
    localparam logic [2:0] CMD_ROT_SEOI  = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic       chip;
        logic       port_a0;
        logic [7:0] data;
        logic [3:0] irq_line;
        logic       level;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] vector;
        logic       vector_valid;
        logic       irq_flag;
    } out_item_t;

    typedef struct packed {
        logic [7:0] irr;
        logic [7:0] last;
        logic [7:0] imr;
        logic [7:0] isr;
        logic [7:0] elcr;
        logic [2:0] prio;
        logic [7:0] base;
        logic [1:0] init;
        logic [5:0] mode;
    } chip_t;

    // rank of first set bit of m, scanning from the priority offset; 8 if none
    function automatic logic [3:0] best_rank(input logic [7:0] m, input logic [2:0] prio);
        logic [7:0] r;
        logic [3:0] res;
        r = (m >> prio) | (m << (4'd8 - {1'b0, prio}));
        res = 4'd8;
        for (int p = 7; p >= 0; p--)
        begin
            if (r[p])
                res = 4'(p);
        end
        return res;
    endfunction

    // eligible line or valid=0
    function automatic logic [3:0] eligible(input chip_t s, input logic is_master);
        logic [3:0] p;
        logic [3:0] q;
        logic [7:0] m;
        p = best_rank(s.irr & ~s.imr, s.prio);
        m = s.isr;
        if (is_master && (s.mode & MF_SFNM) != 6'd0)
            m = m & ~CASC_BIT;
        q = best_rank(m, s.prio);
        if (p != 4'd8 && p < q)
            return {1'b1, p[2:0] + s.prio};
        return 4'd0;
    endfunction

    function automatic chip_t drive(input chip_t s, input logic [2:0] n, input logic lvl);
        chip_t t;
        logic [7:0] b;
        t = s;
        b = 8'd1 << n;
        if ((s.elcr & b) != 8'd0)
        begin
            t.irr = lvl ? (s.irr | b) : (s.irr & ~b);
        end
        else if (lvl && (s.last & b) == 8'd0)
        begin
            t.irr = s.irr | b;
        end
        t.last = lvl ? (s.last | b) : (s.last & ~b);
        return t;
    endfunction

    function automatic chip_t take(input chip_t s, input logic [2:0] n);
        chip_t t;
        logic [7:0] b;
        t = s;
        b = 8'd1 << n;
        if ((s.mode & MF_AEOI) != 6'd0)
        begin
            if ((s.mode & MF_RAEOI) != 6'd0)
                t.prio = n + 3'd1;
        end
        else
        begin
            t.isr = s.isr | b;
        end
        if ((s.elcr & b) == 8'd0)
            t.irr = t.irr & ~b;
        return t;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cic_core.sv
`default_nettype none
module cic_core (
    input  var cic_pkg::chip_t    m_in,
    input  var cic_pkg::chip_t    s_in,
    input  var logic              pend_in,
    input  var cic_pkg::in_item_t item,
    input  var logic [7:0]        mtm,
    input  var logic [7:0]        stm,
    output cic_pkg::chip_t        m_out,
    output cic_pkg::chip_t        s_out,
    output logic                  pend_out,
    output cic_pkg::out_item_t    result
);

    cic_pkg::chip_t ch [2];
    cic_pkg::chip_t cs;
    logic           pend;
    logic           do_eval;
    logic [7:0]     rd;
    logic [7:0]     vec;
    logic           vld;
    logic           c;
    logic [7:0]     v;
    logic [3:0]     el;
    logic [3:0]     sl;
    logic [3:0]     rk;
    logic [2:0]     n;

    // one full step of the controller pair
    always_comb
    begin
        ch[0]   = m_in;
        ch[1]   = s_in;
        pend    = pend_in;
        do_eval = 1'b0;
        rd      = 8'd0;
        vec     = 8'd0;
        vld     = 1'b0;
        c       = item.chip;
        v       = item.data;
        el      = 4'd0;
        sl      = 4'd0;
        rk      = 4'd0;
        n       = 3'd0;
        cs      = ch[c];
        case (cic_pkg::op_t'(item.op))
            cic_pkg::OP_LINE:
            begin
                ch[item.irq_line[3]] = cic_pkg::drive(ch[item.irq_line[3]],
                                                      item.irq_line[2:0], item.level);
                do_eval = 1'b1;
            end
            cic_pkg::OP_PWRITE:
            begin
                if (!item.port_a0)
                begin
                    if ((v & cic_pkg::ICW1_BIT) != 8'd0)
                    begin
                        cs.irr  = 8'd0;
                        cs.last = 8'd0;
                        cs.imr  = 8'd0;
                        cs.isr  = 8'd0;
                        cs.prio = 3'd0;
                        cs.base = 8'd0;
                        cs.mode = v[0] ? cic_pkg::MF_INIT4 : 6'd0;
                        cs.init = 2'd1;
                        pend    = 1'b0;
                    end
                    else if ((v & cic_pkg::OCW3_BIT) != 8'd0)
                    begin
                        if ((v & cic_pkg::POLL_BIT) != 8'd0)
                            cs.mode = cs.mode | cic_pkg::MF_POLL;
                        if (v[1])
                            cs.mode = v[0] ? (cs.mode | cic_pkg::MF_RDISR)
                                           : (cs.mode & ~cic_pkg::MF_RDISR);
                    end
                    else
                    begin
                        case (v[7:5])
                            cic_pkg::CMD_RAEOI_CLR:
                                cs.mode = cs.mode & ~cic_pkg::MF_RAEOI;
                            cic_pkg::CMD_RAEOI_SET:
                                cs.mode = cs.mode | cic_pkg::MF_RAEOI;
                            cic_pkg::CMD_EOI, cic_pkg::CMD_ROT_EOI:
                            begin
                                rk = cic_pkg::best_rank(cs.isr, cs.prio);
                                if (rk != 4'd8)
                                begin
                                    n = rk[2:0] + cs.prio;
                                    cs.isr = cs.isr & ~(8'd1 << n);
                                    if (v[7:5] == cic_pkg::CMD_ROT_EOI)
                                        cs.prio = n + 3'd1;
                                    do_eval = 1'b1;
                                end
                            end
                            cic_pkg::CMD_SEOI:
                            begin
                                cs.isr  = cs.isr & ~(8'd1 << v[2:0]);
                                do_eval = 1'b1;
                            end
                            cic_pkg::CMD_SET_PRIO:
                            begin
                                cs.prio = v[2:0] + 3'd1;
                                do_eval = 1'b1;
                            end
                            cic_pkg::CMD_ROT_SEOI:
                            begin
                                cs.isr  = cs.isr & ~(8'd1 << v[2:0]);
                                cs.prio = v[2:0] + 3'd1;
                                do_eval = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                else
                begin
                    case (cs.init)
                        2'd0:
                        begin
                            cs.imr  = v;
                            do_eval = 1'b1;
                        end
                        2'd1:
                        begin
                            cs.base = v & cic_pkg::BASE_MSK;
                            cs.init = 2'd2;
                        end
                        2'd2:
                            cs.init = ((cs.mode & cic_pkg::MF_INIT4) != 6'd0) ? 2'd3 : 2'd0;
                        default:
                        begin
                            cs.mode = cs.mode & ~(cic_pkg::MF_SFNM | cic_pkg::MF_AEOI);
                            if (v[4])
                                cs.mode = cs.mode | cic_pkg::MF_SFNM;
                            if (v[1])
                                cs.mode = cs.mode | cic_pkg::MF_AEOI;
                            cs.init = 2'd0;
                        end
                    endcase
                end
                ch[c] = cs;
            end
            cic_pkg::OP_PREAD:
            begin
                if ((cs.mode & cic_pkg::MF_POLL) != 6'd0)
                begin
                    cs.mode = cs.mode & ~cic_pkg::MF_POLL;
                    el = cic_pkg::eligible(cs, !c);
                    if (el[3])
                    begin
                        cs.irr = cs.irr & ~(8'd1 << el[2:0]);
                        cs.isr = cs.isr & ~(8'd1 << el[2:0]);
                        ch[c] = cs;
                        if (c)
                        begin
                            ch[0].isr = ch[0].isr & ~cic_pkg::CASC_BIT;
                            ch[0].irr = ch[0].irr & ~cic_pkg::CASC_BIT;
                        end
                        do_eval = c || (el[2:0] != 3'd2);
                        rd = {5'd0, el[2:0]};
                    end
                    else
                    begin
                        ch[c]   = cs;
                        do_eval = 1'b1;
                        rd      = cic_pkg::SPURIOUS;
                    end
                end
                else if (!item.port_a0)
                    rd = ((cs.mode & cic_pkg::MF_RDISR) != 6'd0) ? cs.isr : cs.irr;
                else
                    rd = cs.imr;
            end
            cic_pkg::OP_TWRITE:
            begin
                cs.elcr = v & (c ? stm : mtm);
                ch[c]   = cs;
            end
            cic_pkg::OP_TREAD:
                rd = cs.elcr;
            cic_pkg::OP_ACK:
            begin
                if (pend)
                begin
                    pend = 1'b0;
                    vld  = 1'b1;
                    el   = cic_pkg::eligible(ch[0], 1'b1);
                    if (el[3])
                    begin
                        ch[0] = cic_pkg::take(ch[0], el[2:0]);
                        if (el[2:0] == 3'd2)
                        begin
                            sl = cic_pkg::eligible(ch[1], 1'b0);
                            if (sl[3])
                            begin
                                ch[1] = cic_pkg::take(ch[1], sl[2:0]);
                                vec   = ch[1].base + {5'd0, sl[2:0]};
                            end
                            else
                                vec = ch[1].base + cic_pkg::SPURIOUS;
                        end
                        else
                            vec = ch[0].base + {5'd0, el[2:0]};
                    end
                    else
                        vec = ch[0].base + cic_pkg::SPURIOUS;
                    do_eval = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        // priority evaluation: slave pulses master line 2, then master raises flag
        if (do_eval)
        begin
            if (cic_pkg::eligible(ch[1], 1'b0) != 4'd0)
            begin
                ch[0] = cic_pkg::drive(ch[0], 3'd2, 1'b1);
                ch[0] = cic_pkg::drive(ch[0], 3'd2, 1'b0);
            end
            if (cic_pkg::eligible(ch[0], 1'b1) != 4'd0)
                pend = 1'b1;
        end
        m_out               = ch[0];
        s_out               = ch[1];
        pend_out            = pend;
        result.read_data    = rd;
        result.vector       = vec;
        result.vector_valid = vld;
        result.irq_flag     = pend;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/cascaded_interrupt_controller.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// command   in         start & !busy        cmd (in_item_t)
// result    out        result_valid strobe  result (out_item_t)
// config    in         cfg_valid & cfg_ready cfg_index, cfg_data
//
// One transaction is accepted every cycle; busy is always low. The result
// appears in the cycle after acceptance, for one cycle, from the output register.
// The state update is one combinational pass over both controllers' state.
// Reset is asynchronous, active low; trigger masks reset to 0xF8 and 0xDE.
// The receiver cannot stall; cfg_ready is always high.
module cascaded_interrupt_controller (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    output logic                    busy,
    input  var cic_pkg::in_item_t   cmd,
    output logic                    result_valid,
    output cic_pkg::out_item_t      result,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire                     cfg_index,
    input  wire [7:0]               cfg_data
);

    cic_pkg::chip_t     m_reg, s_reg, m_next, s_next;
    logic               pend_reg, pend_next;
    logic [7:0]         mtm_reg, stm_reg;
    cic_pkg::out_item_t res_next, res_reg;
    logic               rv_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    cic_core u_core (
        .m_in     (m_reg),
        .s_in     (s_reg),
        .pend_in  (pend_reg),
        .item     (cmd),
        .mtm      (mtm_reg),
        .stm      (stm_reg),
        .m_out    (m_next),
        .s_out    (s_next),
        .pend_out (pend_next),
        .result   (res_next)
    );

    // advance state on each accepted transaction and load the trigger masks on config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg    <= '0;
            s_reg    <= '0;
            pend_reg <= 1'b0;
            rv_reg   <= 1'b0;
            mtm_reg  <= 8'hF8;
            stm_reg  <= 8'hDE;
        end
        else
        begin
            rv_reg <= start;
            if (start)
            begin
                m_reg    <= m_next;
                s_reg    <= s_next;
                pend_reg <= pend_next;
            end
            if (cfg_valid)
            begin
                if (!cfg_index)
                    mtm_reg <= cfg_data;
                else
                    stm_reg <= cfg_data;
            end
        end
    end

    // hold result payload
    always_ff @(posedge clk)
    begin
        if (start)
            res_reg <= res_next;
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        bit                 is_cfg;
        cic_pkg::in_item_t  item;
        bit                 idx;
        logic [7:0]         val;
    } job_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    cic_pkg::in_item_t  cmd = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_index = 1'b0;
    logic [7:0]         cfg_data = 8'd0;
    wire                busy;
    wire                result_valid;
    wire                cfg_ready;
    cic_pkg::out_item_t result;

    cascaded_interrupt_controller DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // controller model state, index 0 master, 1 slave
    logic [7:0] trig_mask [2] = '{8'hF8, 8'hDE};
    logic [7:0] irr [2] = '{0, 0};
    logic [7:0] prev_lvl [2] = '{0, 0};
    logic [7:0] imr [2] = '{0, 0};
    logic [7:0] isr [2] = '{0, 0};
    logic [7:0] elcr [2] = '{0, 0};
    logic [2:0] low_prio [2] = '{0, 0};
    logic [7:0] vbase [2] = '{0, 0};
    logic [1:0] istep [2] = '{0, 0};
    logic [5:0] mflags [2] = '{0, 0};
    logic       pend = 1'b0;

    job_t               work_q [$];
    cic_pkg::out_item_t expected_q [$];
    int                 errs = 0;
    int                 n_items = 0;
    int                 n_vectors = 0;
    int                 n_cfg = 0;
    int                 quiet = 0;
    longint             cyc = 0;

    function void line_drive(int c, int n, bit l);
        logic [7:0] b;
        b = 8'd1 << n;
        if ((elcr[c] & b) != 0)
        begin
            irr[c] = l ? (irr[c] | b) : (irr[c] & ~b);
            prev_lvl[c] = l ? (prev_lvl[c] | b) : (prev_lvl[c] & ~b);
        end
        else if (l)
        begin
            if ((prev_lvl[c] & b) == 0)
                irr[c] = irr[c] | b;
            prev_lvl[c] = prev_lvl[c] | b;
        end
        else
            prev_lvl[c] = prev_lvl[c] & ~b;
    endfunction

    function int prio_rank(int c, logic [7:0] m);
        for (int p = 0; p < 8; p++)
            if (m[(p + low_prio[c]) & 7])
                return p;
        return 8;
    endfunction

    // highest priority unmasked request that beats the in-service set, or -1
    function int winner(int c);
        int p;
        logic [7:0] m;
        p = prio_rank(c, irr[c] & ~imr[c]);
        m = isr[c];
        if (p == 8)
            return -1;
        if ((mflags[c] & cic_pkg::MF_SFNM) != 0 && c == 0)
            m = m & ~cic_pkg::CASC_BIT;
        if (p < prio_rank(c, m))
            return (p + low_prio[c]) & 7;
        return -1;
    endfunction

    function void reevaluate();
        if (winner(1) >= 0)
        begin
            line_drive(0, 2, 1'b1);
            line_drive(0, 2, 1'b0);
        end
        if (winner(0) >= 0)
            pend = 1'b1;
    endfunction

    function void mark_taken(int c, int n);
        logic [7:0] b;
        b = 8'd1 << n;
        if ((mflags[c] & cic_pkg::MF_AEOI) != 0)
        begin
            if ((mflags[c] & cic_pkg::MF_RAEOI) != 0)
                low_prio[c] = 3'(n + 1);
        end
        else
            isr[c] = isr[c] | b;
        if ((elcr[c] & b) == 0)
            irr[c] = irr[c] & ~b;
    endfunction

    function void reg_write(int c, bit a0, logic [7:0] v);
        logic [2:0] code;
        int p;
        int n;
        if (!a0)
        begin
            code = v[7:5];
            if ((v & cic_pkg::ICW1_BIT) != 0)
            begin
                irr[c] = 0; prev_lvl[c] = 0; imr[c] = 0; isr[c] = 0;
                low_prio[c] = 0; vbase[c] = 0;
                mflags[c] = v[0] ? cic_pkg::MF_INIT4 : 6'd0;
                pend = 1'b0;
                istep[c] = 2'd1;
            end
            else if ((v & cic_pkg::OCW3_BIT) != 0)
            begin
                if ((v & cic_pkg::POLL_BIT) != 0)
                    mflags[c] = mflags[c] | cic_pkg::MF_POLL;
                if (v[1])
                    mflags[c] = v[0] ? (mflags[c] | cic_pkg::MF_RDISR)
                                     : (mflags[c] & ~cic_pkg::MF_RDISR);
            end
            else
            begin
                case (code)
                    cic_pkg::CMD_RAEOI_CLR: mflags[c] = mflags[c] & ~cic_pkg::MF_RAEOI;
                    cic_pkg::CMD_RAEOI_SET: mflags[c] = mflags[c] | cic_pkg::MF_RAEOI;
                    cic_pkg::CMD_EOI, cic_pkg::CMD_ROT_EOI:
                    begin
                        p = prio_rank(c, isr[c]);
                        if (p != 8)
                        begin
                            n = (p + low_prio[c]) & 7;
                            isr[c][n] = 1'b0;
                            if (code == cic_pkg::CMD_ROT_EOI)
                                low_prio[c] = 3'(n + 1);
                            reevaluate();
                        end
                    end
                    cic_pkg::CMD_SEOI:
                    begin
                        isr[c][v[2:0]] = 1'b0;
                        reevaluate();
                    end
                    cic_pkg::CMD_SET_PRIO:
                    begin
                        low_prio[c] = v[2:0] + 3'd1;
                        reevaluate();
                    end
                    cic_pkg::CMD_ROT_SEOI:
                    begin
                        isr[c][v[2:0]] = 1'b0;
                        low_prio[c] = v[2:0] + 3'd1;
                        reevaluate();
                    end
                    default: ;
                endcase
            end
        end
        else
        begin
            case (istep[c])
                2'd0:
                begin
                    imr[c] = v;
                    reevaluate();
                end
                2'd1:
                begin
                    vbase[c] = v & cic_pkg::BASE_MSK;
                    istep[c] = 2'd2;
                end
                2'd2: istep[c] = ((mflags[c] & cic_pkg::MF_INIT4) != 0) ? 2'd3 : 2'd0;
                default:
                begin
                    mflags[c] = mflags[c] & ~(cic_pkg::MF_SFNM | cic_pkg::MF_AEOI);
                    if (v[4])
                        mflags[c] = mflags[c] | cic_pkg::MF_SFNM;
                    if (v[1])
                        mflags[c] = mflags[c] | cic_pkg::MF_AEOI;
                    istep[c] = 2'd0;
                end
            endcase
        end
    endfunction

    function logic [7:0] reg_read(int c, bit a0);
        int r;
        if ((mflags[c] & cic_pkg::MF_POLL) != 0)
        begin
            mflags[c] = mflags[c] & ~cic_pkg::MF_POLL;
            r = winner(c);
            if (r >= 0)
            begin
                if (c == 1)
                begin
                    isr[0] = isr[0] & ~cic_pkg::CASC_BIT;
                    irr[0] = irr[0] & ~cic_pkg::CASC_BIT;
                end
                irr[c][r] = 1'b0;
                isr[c][r] = 1'b0;
                if (c == 1 || r != 2)
                    reevaluate();
                return 8'(r);
            end
            reevaluate();
            return cic_pkg::SPURIOUS;
        end
        if (!a0)
            return ((mflags[c] & cic_pkg::MF_RDISR) != 0) ? isr[c] : irr[c];
        return imr[c];
    endfunction

    function logic [7:0] intack();
        int n;
        int s;
        logic [7:0] vec;
        n = winner(0);
        if (n >= 0)
        begin
            mark_taken(0, n);
            if (n == 2)
            begin
                s = winner(1);
                if (s >= 0)
                    mark_taken(1, s);
                else
                    s = cic_pkg::SPURIOUS;
                vec = vbase[1] + 8'(s);
            end
            else
                vec = vbase[0] + 8'(n);
        end
        else
            vec = vbase[0] + cic_pkg::SPURIOUS;
        reevaluate();
        return vec;
    endfunction

    function cic_pkg::out_item_t predict_result(cic_pkg::in_item_t it);
        cic_pkg::out_item_t o;
        o = '0;
        case (cic_pkg::op_t'(it.op))
            cic_pkg::OP_LINE:
            begin
                line_drive(it.irq_line[3], it.irq_line[2:0], it.level);
                reevaluate();
            end
            cic_pkg::OP_PWRITE: reg_write(it.chip, it.port_a0, it.data);
            cic_pkg::OP_PREAD:  o.read_data = reg_read(it.chip, it.port_a0);
            cic_pkg::OP_TWRITE: elcr[it.chip] = it.data & trig_mask[it.chip];
            cic_pkg::OP_TREAD:  o.read_data = elcr[it.chip];
            cic_pkg::OP_ACK:
            begin
                if (pend)
                begin
                    pend = 1'b0;
                    o.vector = intack();
                    o.vector_valid = 1'b1;
                end
            end
            default: ;
        endcase
        o.irq_flag = pend;
        return o;
    endfunction

    // drive command and config transactions from the work queue
    always @(posedge clk)
    begin
        job_t j;
        bit   nxt_start;
        bit   nxt_cfg;
        bit   no_idle;
        if (rst_n)
        begin
            cyc++;
            quiet = start ? 0 : quiet + 1;
            nxt_start = start && busy;
            nxt_cfg = cfg_valid && !cfg_ready;
            no_idle = (cyc >= 600) && (cyc < 1400);
            if (!nxt_start && !nxt_cfg && work_q.size() > 0)
            begin
                if (work_q[0].is_cfg)
                begin
                    if (quiet >= 4 && !cfg_valid)
                    begin
                        j = work_q.pop_front();
                        cfg_index <= j.idx;
                        cfg_data <= j.val;
                        nxt_cfg = 1'b1;
                    end
                end
                else if (no_idle || $urandom_range(99) >= 24)
                begin
                    j = work_q.pop_front();
                    cmd <= j.item;
                    nxt_start = 1'b1;
                end
            end
            start <= nxt_start;
            cfg_valid <= nxt_cfg;
        end
    end

    // check results, then update the model on accepted transactions
    always @(posedge clk)
    begin
        cic_pkg::out_item_t e;
        cic_pkg::out_item_t pr;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    errs++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (result.read_data !== e.read_data || result.vector !== e.vector ||
                        result.vector_valid !== e.vector_valid ||
                        result.irq_flag !== e.irq_flag)
                    begin
                        $display("%0t: mismatch expected rd=%h vec=%h vv=%b irq=%b",
                                 $time, e.read_data, e.vector, e.vector_valid, e.irq_flag);
                        $display("%0t:          actual   rd=%h vec=%h vv=%b irq=%b",
                                 $time, result.read_data, result.vector,
                                 result.vector_valid, result.irq_flag);
                        errs++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                trig_mask[cfg_index] = cfg_data;
                n_cfg++;
            end
            if (start && !busy)
            begin
                pr = predict_result(cmd);
                if (pr.vector_valid)
                    n_vectors++;
                expected_q.push_back(pr);
                n_items++;
            end
        end
    end

    task automatic add_op(cic_pkg::op_t op, bit chip, bit a0, logic [7:0] d,
                          logic [3:0] ln, bit l);
        job_t j;
        j.is_cfg = 1'b0;
        j.item.op = op;
        j.item.chip = chip;
        j.item.port_a0 = a0;
        j.item.data = d;
        j.item.irq_line = ln;
        j.item.level = l;
        j.idx = 1'b0;
        j.val = 8'd0;
        work_q.push_back(j);
    endtask

    task automatic add_cfg(bit idx, logic [7:0] v);
        job_t j;
        j.is_cfg = 1'b1;
        j.item = '0;
        j.idx = idx;
        j.val = v;
        work_q.push_back(j);
    endtask

    task automatic add_init(bit chip, logic [7:0] base, bit icw4, logic [7:0] w4);
        add_op(cic_pkg::OP_PWRITE, chip, 1'b0, cic_pkg::ICW1_BIT | 8'(icw4), 4'd0, 1'b0);
        add_op(cic_pkg::OP_PWRITE, chip, 1'b1, base, 4'd0, 1'b0);
        add_op(cic_pkg::OP_PWRITE, chip, 1'b1, chip ? 8'h02 : 8'h04, 4'd0, 1'b0);
        if (icw4)
            add_op(cic_pkg::OP_PWRITE, chip, 1'b1, w4, 4'd0, 1'b0);
    endtask

    task automatic add_random();
        int  k;
        bit  ch;
        logic [7:0] d;
        k = $urandom_range(99);
        ch = $urandom_range(1);
        d = $urandom;
        if (k < 35)
            add_op(cic_pkg::OP_LINE, ch, $urandom_range(1), d, 4'($urandom),
                   $urandom_range(1));
        else if (k < 38)
            add_op(cic_pkg::op_t'($urandom_range(7)), ch, $urandom_range(1), d,
                   4'($urandom), $urandom_range(1));
        else if (k < 40)
            add_init(ch, d, $urandom_range(1), 8'($urandom));
        else if (k < 52)
            add_op(cic_pkg::OP_PWRITE, ch, 1'b0,
                   {$urandom_range(7) == 2 ? cic_pkg::CMD_NOP : 3'($urandom),
                    2'b00, d[2:0]}, 4'd0, 1'b0);
        else if (k < 57)
            add_op(cic_pkg::OP_PWRITE, ch, 1'b0, (d & 8'he7) | cic_pkg::OCW3_BIT,
                   4'd0, 1'b0);
        else if (k < 62)
            add_op(cic_pkg::OP_PWRITE, ch, 1'b1, d, 4'd0, 1'b0);
        else if (k < 70)
            add_op(cic_pkg::OP_PREAD, ch, $urandom_range(1), d, 4'd0, 1'b0);
        else if (k < 74)
            add_op(cic_pkg::OP_TWRITE, ch, 1'b0, d, 4'd0, 1'b0);
        else if (k < 77)
            add_op(cic_pkg::OP_TREAD, ch, 1'b0, d, 4'd0, 1'b0);
        else
            add_op(cic_pkg::OP_ACK, ch, 1'b0, d, 4'd0, 1'b0);
    endtask

    // stimulus
    initial
    begin
        logic [7:0] cfg_vals [5][2];
        cfg_vals = '{'{8'hFF, 8'hFF}, '{8'h00, 8'h00}, '{8'hF8, 8'hDE},
                     '{8'h5A, 8'hA5}, '{8'hFF, 8'h00}};
        add_cfg(1'b0, 8'hFF);
        add_cfg(1'b1, 8'hFF);
        // directed: unprogrammed ack, full init, cascade, poll, rotation
        add_op(cic_pkg::OP_ACK, 1'b0, 1'b0, 8'd0, 4'd0, 1'b0);
        add_init(1'b0, 8'hFF, 1'b1, 8'h01);
        add_init(1'b1, 8'h28, 1'b1, 8'h00);
        add_op(cic_pkg::OP_TWRITE, 1'b0, 1'b0, 8'hFF, 4'd0, 1'b0);
        add_op(cic_pkg::OP_TREAD, 1'b0, 1'b0, 8'd0, 4'd0, 1'b0);
        add_op(cic_pkg::OP_LINE, 1'b0, 1'b0, 8'd0, 4'd15, 1'b1);
        add_op(cic_pkg::OP_ACK, 1'b0, 1'b0, 8'd0, 4'd0, 1'b0);
        add_op(cic_pkg::OP_LINE, 1'b0, 1'b0, 8'd0, 4'd0, 1'b1);
        add_op(cic_pkg::OP_PWRITE, 1'b0, 1'b0, 8'h0B, 4'd0, 1'b0);
        add_op(cic_pkg::OP_PREAD, 1'b0, 1'b0, 8'd0, 4'd0, 1'b0);
        add_op(cic_pkg::OP_ACK, 1'b0, 1'b0, 8'd0, 4'd0, 1'b0);
        add_op(cic_pkg::OP_PWRITE, 1'b0, 1'b0, {cic_pkg::CMD_EOI, 5'd0}, 4'd0, 1'b0);
        add_op(cic_pkg::OP_PWRITE, 1'b1, 1'b0, {cic_pkg::CMD_ROT_EOI, 5'd0}, 4'd0, 1'b0);
        add_op(cic_pkg::OP_PWRITE, 1'b0, 1'b0, {cic_pkg::CMD_NOP, 5'd0}, 4'd0, 1'b0);
        add_op(cic_pkg::OP_LINE, 1'b0, 1'b0, 8'd0, 4'd0, 1'b0);
        add_op(cic_pkg::OP_PWRITE, 1'b0, 1'b0, 8'h0C, 4'd0, 1'b0);
        add_op(cic_pkg::OP_PREAD, 1'b0, 1'b0, 8'd0, 4'd0, 1'b0);
        add_op(cic_pkg::OP_PWRITE, 1'b0, 1'b0, {cic_pkg::CMD_SET_PRIO, 5'd7}, 4'd0, 1'b0);
        add_op(cic_pkg::OP_PWRITE, 1'b0, 1'b0, {cic_pkg::CMD_ROT_SEOI, 5'd2}, 4'd0, 1'b0);
        add_op(cic_pkg::OP_PWRITE, 1'b0, 1'b1, 8'hFF, 4'd0, 1'b0);
        add_op(cic_pkg::OP_PREAD, 1'b0, 1'b1, 8'd0, 4'd0, 1'b0);
        add_op(cic_pkg::OP_RSVD7, 1'b1, 1'b1, 8'hFF, 4'd15, 1'b1);
        for (int ph = 0; ph < 5; ph++)
        begin
            add_cfg(1'b0, (ph == 3) ? 8'($urandom) : cfg_vals[ph][0]);
            add_cfg(1'b1, (ph == 3) ? 8'($urandom) : cfg_vals[ph][1]);
            add_init(1'b0, 8'($urandom), 1'b1, 8'($urandom) & 8'h12);
            add_init(1'b1, 8'($urandom), $urandom_range(1), 8'($urandom) & 8'h12);
            for (int i = 0; i < 300; i++)
                add_random();
        end
    end

    // reset, then wait for the work to drain
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (work_q.size() > 0 || start || cfg_valid)
            @(posedge clk);
        while (expected_q.size() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        $display("covered %0d transactions, %0d vectors delivered, %0d register writes",
                 n_items, n_vectors, n_cfg);
        if (errs == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("testbench failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/cic_pkg.sv
hw/rtl/cic_core.sv
hw/rtl/cascaded_interrupt_controller.sv
test/testbench.sv
